// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== src/aes_pkg.sv =====
// Shared types, constants and round functions of the AES-256 CBC block
package aes_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned RkDepth   = 2 * (NumRounds + 1);
  localparam int unsigned RkAw      = 5;
  localparam int unsigned WordCnt   = 4 * (NumRounds + 1);

  // configuration register indexes
  localparam logic [2:0] CfgMode = 3'd0;
  localparam logic [2:0] CfgKey0 = 3'd1;
  localparam logic [2:0] CfgKey1 = 3'd2;
  localparam logic [2:0] CfgKey2 = 3'd3;
  localparam logic [2:0] CfgKey3 = 3'd4;
  localparam logic [2:0] CfgIvHi = 3'd5;
  localparam logic [2:0] CfgIvLo = 3'd6;

  typedef enum logic [2:0] {
    StIdle, StKeyExp, StLoadRk, StRound, StFinish, StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load_in;     // capture item, apply chaining (and key 0 xor via round)
    logic       ke_start;    // load key registers into expansion window
    logic       ke_step;     // advance the expansion window by eight words
    logic [RkAw-1:0] rk_waddr;
    logic       rk_we;
    logic       rk_re;
    logic [RkAw-1:0] rk_raddr;
    logic       rk_read_lo;  // second half requested, first half captured
    logic       do_round;    // apply a round with the current key
    logic       first_rnd;   // key xor only
    logic       last_rnd;    // no mix
    logic       finish;      // result and chain update
  } dp_cmd_t;

  typedef struct packed {
    logic dummy;
  } dp_sts_t;

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte i of the state is bits 127-8i
  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[c*4+r] = sbox(b[((c+r)%4)*4+r]);
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (!last) begin
        t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    fwd_round = o;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] x, input logic [3:0] m);
    logic [7:0] x2, x4, x8;
    x2 = xt(x); x4 = xt(x2); x8 = xt(x4);
    gm = (m[0] ? x : 8'h00) ^ (m[1] ? x2 : 8'h00) ^ (m[2] ? x4 : 8'h00) ^ (m[3] ? x8 : 8'h00);
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) o[127-8*(c*4+r) -: 8] = inv_sbox(b[((c-r+4)%4)*4+r]);
    inv_sub_shift = o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a [4];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = gm(a[r], 4'he) ^ gm(a[(r+1)%4], 4'hb) ^
                                gm(a[(r+2)%4], 4'hd) ^ gm(a[(r+3)%4], 4'h9);
    end
    inv_mix = o;
  endfunction

endpackage

// ===== src/aes_ram.sv =====
// Generic single-port-write, registered-read RAM
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/aes_ctrl.sv =====
// Sequencer for key expansion and the round loop
`include "assert_macros.svh"
module aes_ctrl import aes_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    first_i,
  input  logic    mode_i,
  input  logic    out_busy_i,
  output logic    out_load_o,
  output dp_cmd_t cmd_o
);
  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;   // expansion step or round counter
  logic       dec_q, dec_d;
  logic       ph_q, ph_d;     // key half phase

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    dec_d = dec_q;
    ph_d = ph_q;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        dec_d = mode_i;
        cnt_d = '0;
        state_d = first_i ? StKeyExp : StLoadRk;
      end
      StKeyExp: begin
        // 30 entry writes: a 256-bit window gives four entries, seven steps move it on
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(RkDepth - 1)) begin
          state_d = StLoadRk;
          cnt_d = '0;
        end
      end
      StLoadRk: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          ph_d = 1'b0;
          state_d = StRound;
        end
      end
      StRound: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          ph_d = 1'b0;
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'(NumRounds)) state_d = StFinish;
        end
      end
      StFinish: state_d = StOut;
      StOut: if (!out_busy_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // round key index in use for round count c, and the one fetched next
  logic [4:0] rk_idx;
  logic [4:0] nxt_idx;
  assign rk_idx = dec_q ? 5'(NumRounds) - cnt_d : cnt_d;
  assign nxt_idx = dec_q ? 5'(NumRounds) - (cnt_q + 5'd1) : cnt_q + 5'd1;

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load_in = in_valid_i;
        cmd_o.ke_start = in_valid_i & first_i;
      end
      StKeyExp: begin
        cmd_o.rk_we = 1'b1;
        cmd_o.rk_waddr = cnt_q;
        cmd_o.ke_step = (cnt_q[1:0] == 2'd3);
      end
      StLoadRk: begin
        cmd_o.rk_re = 1'b1;
        cmd_o.rk_raddr = {rk_idx[3:0], ph_q};
        cmd_o.rk_read_lo = ph_q;
      end
      StRound: begin
        // key is complete in phase 0; fetch the next key over both phases
        cmd_o.rk_re = (cnt_q != 5'(NumRounds));
        cmd_o.rk_raddr = {nxt_idx[3:0], ph_q};
        cmd_o.rk_read_lo = ph_q;
        cmd_o.do_round = ~ph_q;
        cmd_o.first_rnd = (cnt_q == 5'd0);
        cmd_o.last_rnd = (cnt_q == 5'(NumRounds));
      end
      StFinish: cmd_o.finish = 1'b1;
      StOut: out_load_o = !out_busy_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      dec_q <= 1'b0;
      ph_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      dec_q <= dec_d;
      ph_q <= ph_d;
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == StIdle)
  `ASSERT_IMPL(a_round_bound, clk_i, rst_ni, state_q == StRound, cnt_q <= 5'(NumRounds))
  `ASSERT_NEXT(a_fin_out, clk_i, rst_ni, state_q == StFinish, state_q == StOut)
endmodule

// ===== src/aes_dp.sv =====
// Datapath: key expansion, round key store, round unit and CBC chain
`include "assert_macros.svh"
module aes_dp import aes_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dp_cmd_t       cmd_i,
  input  logic          dec_i,
  input  logic [255:0]  key_i,
  input  logic [127:0]  iv_i,
  input  logic [127:0]  blk_i,
  input  logic          first_i,
  output logic [127:0]  res_o
);
  logic [255:0] win_q, win_d;      // last eight expansion words
  logic [7:0]   rc_q, rc_d;
  logic [127:0] st_q, st_d;
  logic [127:0] cin_q;             // ciphertext input kept for decrypt chaining
  logic [127:0] chain_q, chain_d;
  logic [63:0]  rk_hi_q;
  logic [63:0]  rk_rd;
  logic [63:0]  rk_wd;

  // next 256-bit window of the schedule
  always_comb begin
    logic [31:0] w [16];
    logic [31:0] t;
    for (int i = 0; i < 8; i++) w[i] = win_q[255-32*i -: 32];
    for (int i = 8; i < 16; i++) begin
      t = w[i-1];
      if (i == 8) t = sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
      else if (i == 12) t = sub_word(t);
      w[i] = w[i-8] ^ t;
    end
    for (int i = 0; i < 8; i++) win_d[255-32*i -: 32] = w[i+8];
    rc_d = xt(rc_q);
  end

  assign rk_wd = win_q[255-64*cmd_i.rk_waddr[1:0] -: 64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chain_q <= '0;
    else chain_q <= chain_d;
  end

  aes_ram #(.Width(64), .Depth(RkDepth)) u_rk (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rk_we),
    .waddr_i (cmd_i.rk_waddr),
    .wdata_i (rk_wd),
    .re_i    (cmd_i.rk_re),
    .raddr_i (cmd_i.rk_raddr),
    .rdata_o (rk_rd)
  );

  // round datapath
  logic [127:0] key_now;
  assign key_now = {rk_hi_q, rk_rd};
  always_comb begin
    st_d = st_q;
    chain_d = first_i & cmd_i.load_in ? iv_i : chain_q;
    if (cmd_i.load_in) st_d = dec_i ? blk_i : blk_i ^ chain_d;
    if (cmd_i.do_round) begin
      if (cmd_i.first_rnd) st_d = st_q ^ key_now;
      else if (!dec_i) st_d = fwd_round(st_q, cmd_i.last_rnd) ^ key_now;
      else if (cmd_i.last_rnd) st_d = inv_sub_shift(st_q) ^ key_now;
      else st_d = inv_mix(inv_sub_shift(st_q) ^ key_now);
    end
    if (cmd_i.finish) begin
      st_d = dec_i ? st_q ^ chain_q : st_q;
      chain_d = dec_i ? cin_q : st_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (cmd_i.load_in) cin_q <= blk_i;
    if (cmd_i.rk_re && cmd_i.rk_read_lo) rk_hi_q <= rk_rd;
    if (cmd_i.ke_start) begin
      win_q <= key_i;
      rc_q <= 8'h01;
    end else if (cmd_i.ke_step) begin
      win_q <= win_d;
      rc_q <= rc_d;
    end
  end

  assign res_o = st_q;

  `ASSERT_IMPL(a_one_cmd, clk_i, rst_ni, 1'b1,
    $countones({cmd_i.load_in, cmd_i.do_round, cmd_i.finish}) <= 1)
  `ASSERT_IMPL(a_no_wr_rd, clk_i, rst_ni, cmd_i.rk_we, !cmd_i.rk_re)
endmodule

// ===== src/aes256_cbc_block_cipher.sv =====
// Top level of the AES-256 CBC block cipher
//  channel | signals                               | direction
//  in      | in_valid/ready, block_*, first/last   | sink
//  out     | out_valid/ready, result_*             | source
//  cfg     | cfg_valid/ready, cfg_index, cfg_data  | sink
// After acceptance an item fetches round key 0 in halves over the 64-bit key read
// port, runs 15 key additions while fetching each next key, finishes the chain and
// loads the output register; only then is the input ready for the next item.
// A first block runs the key expansion before the rounds.
// Reset clears control and the chain; the key store is filled on first block.
// A held result stalls the next item at its output step and then the input.
`include "assert_macros.svh"
module aes256_cbc_block_cipher import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        first_block_i,
  input  logic        last_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  output logic        result_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  logic         mode_q;
  logic [255:0] key_q;
  logic [127:0] iv_q;
  logic         last_in_q;
  logic         last_q;
  logic         out_valid_q;
  logic [127:0] res, res_q;
  logic         out_load;
  dp_cmd_t      cmd;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      key_q <= '0;
      iv_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMode: mode_q <= cfg_data_i[0];
        CfgKey0: key_q[255:192] <= cfg_data_i;
        CfgKey1: key_q[191:128] <= cfg_data_i;
        CfgKey2: key_q[127:64] <= cfg_data_i;
        CfgKey3: key_q[63:0] <= cfg_data_i;
        CfgIvHi: iv_q[127:64] <= cfg_data_i;
        CfgIvLo: iv_q[63:0] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .first_i    (first_block_i),
    .mode_i     (mode_q),
    .out_busy_i (out_valid_q),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  aes_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .dec_i   (mode_q),
    .key_i   (key_q),
    .iv_i    (iv_q),
    .blk_i   ({block_high_i, block_low_i}),
    .first_i (first_block_i),
    .res_o   (res)
  );

  // output register; the last flag rides with the item until its result loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) last_in_q <= last_block_i;
    if (out_load) begin
      res_q <= res;
      last_q <= last_in_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign {result_high_o, result_low_o} = res_q;
  assign result_last_o = last_q;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule
